@@ rtl/core/msd_pkg.sv @@
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, queue sizing and the Morse code table of the symbol decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

    // Symbol codes on the input field
    localparam logic [1:0] SYM_DOT  = 2'd0;
    localparam logic [1:0] SYM_DASH = 2'd1;
    localparam logic [1:0] SYM_SEP  = 2'd2;

    // Letter buffer limits
    localparam int MAX_SYMBOLS = 5;
    localparam int LEN_W       = 3;
    localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(MAX_SYMBOLS);
    localparam logic [LEN_W-1:0] LEN_OVERFLOW = LEN_W'(MAX_SYMBOLS + 1);

    // Output status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Depth of the command queue and of the result queue
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Finished code handed from front to back
    typedef struct packed {
        logic [MAX_SYMBOLS-1:0] bits;
        logic [LEN_W-1:0]       len;
    } t_code;

    // One decoded result
    typedef struct packed {
        logic [6:0] char_code;
        logic       status;
    } t_result;

    // Table of letters and digits; bit i of bits is symbol i, 1 = dash.
    // Returns 0 for a code not in the table, including the overflow length.
    function automatic logic [6:0] lookup_code(input logic [LEN_W-1:0] len,
                                               input logic [MAX_SYMBOLS-1:0] bits);
        logic [6:0] ch;
        ch = 7'h00;
        unique case ({len, bits})
            {3'd1, 5'd0}:  ch = 7'h45; // E
            {3'd1, 5'd1}:  ch = 7'h54; // T
            {3'd2, 5'd0}:  ch = 7'h49; // I
            {3'd2, 5'd1}:  ch = 7'h4E; // N
            {3'd2, 5'd2}:  ch = 7'h41; // A
            {3'd2, 5'd3}:  ch = 7'h4D; // M
            {3'd3, 5'd0}:  ch = 7'h53; // S
            {3'd3, 5'd1}:  ch = 7'h44; // D
            {3'd3, 5'd2}:  ch = 7'h52; // R
            {3'd3, 5'd3}:  ch = 7'h47; // G
            {3'd3, 5'd4}:  ch = 7'h55; // U
            {3'd3, 5'd5}:  ch = 7'h4B; // K
            {3'd3, 5'd6}:  ch = 7'h57; // W
            {3'd3, 5'd7}:  ch = 7'h4F; // O
            {3'd4, 5'd0}:  ch = 7'h48; // H
            {3'd4, 5'd1}:  ch = 7'h42; // B
            {3'd4, 5'd2}:  ch = 7'h4C; // L
            {3'd4, 5'd3}:  ch = 7'h5A; // Z
            {3'd4, 5'd4}:  ch = 7'h46; // F
            {3'd4, 5'd5}:  ch = 7'h43; // C
            {3'd4, 5'd6}:  ch = 7'h50; // P
            {3'd4, 5'd8}:  ch = 7'h56; // V
            {3'd4, 5'd9}:  ch = 7'h58; // X
            {3'd4, 5'd11}: ch = 7'h51; // Q
            {3'd4, 5'd13}: ch = 7'h59; // Y
            {3'd4, 5'd14}: ch = 7'h4A; // J
            {3'd5, 5'd0}:  ch = 7'h35; // 5
            {3'd5, 5'd1}:  ch = 7'h36; // 6
            {3'd5, 5'd3}:  ch = 7'h37; // 7
            {3'd5, 5'd7}:  ch = 7'h38; // 8
            {3'd5, 5'd15}: ch = 7'h39; // 9
            {3'd5, 5'd16}: ch = 7'h34; // 4
            {3'd5, 5'd24}: ch = 7'h33; // 3
            {3'd5, 5'd28}: ch = 7'h32; // 2
            {3'd5, 5'd30}: ch = 7'h31; // 1
            {3'd5, 5'd31}: ch = 7'h30; // 0
            default:       ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/core/msd_front.sv @@
// ----------------------------------------------------------------------------
// msd_front
// Collects dots and dashes of the letter in progress and emits the finished
// code on a separator or an end-of-message mark.
// ----------------------------------------------------------------------------
module msd_front import msd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_symbol,
    input  logic       i_end_of_message,
    output logic       o_code_valid,
    output t_code      o_code
);

    logic [MAX_SYMBOLS-1:0] r_code_bits, n_code_bits;
    logic [LEN_W-1:0]       r_code_len,  n_code_len;
    logic [MAX_SYMBOLS-1:0] upd_bits;
    logic [LEN_W-1:0]       upd_len;
    logic                   is_mark;
    logic                   flush;

    // Classify the symbol and append dots and dashes
    always_comb begin
        is_mark  = (i_symbol == SYM_DOT) || (i_symbol == SYM_DASH);
        upd_bits = r_code_bits;
        upd_len  = r_code_len;
        if (is_mark) begin
            if (r_code_len < LEN_MAX) begin
                upd_bits = r_code_bits
                         | (MAX_SYMBOLS'(i_symbol == SYM_DASH) << r_code_len);
                upd_len  = r_code_len + LEN_W'(1);
            end else begin
                upd_len  = LEN_OVERFLOW;
            end
        end
        flush = (!is_mark && (r_code_len != '0))
             || (i_end_of_message && (upd_len != '0));
    end

    // Hold the buffer, clear it on every flush
    always_comb begin
        n_code_bits = r_code_bits;
        n_code_len  = r_code_len;
        if (i_accept) begin
            if (flush) begin
                n_code_bits = '0;
                n_code_len  = '0;
            end else begin
                n_code_bits = upd_bits;
                n_code_len  = upd_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits <= '0;
            r_code_len  <= '0;
        end else begin
            r_code_bits <= n_code_bits;
            r_code_len  <= n_code_len;
        end
    end

    assign o_code_valid = i_accept && flush;
    assign o_code.bits  = upd_bits;
    assign o_code.len   = upd_len;

endmodule

@@ rtl/core/msd_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// msd_cmd_queue
// Short register queue of finished codes between the front and the back.
// ----------------------------------------------------------------------------
module msd_cmd_queue import msd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_code i_wr_data,
    output logic  o_full,
    input  logic  i_rd,
    output t_code o_rd_data,
    output logic  o_empty
);

    t_code            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_wr, do_rd;

    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entry payload
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

@@ rtl/core/msd_back.sv @@
// ----------------------------------------------------------------------------
// msd_back
// Looks finished codes up in the letter and digit table, applies the case
// setting and queues the results for the consumer.
// ----------------------------------------------------------------------------
module msd_back import msd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_lower_case,
    input  logic       i_code_valid,
    input  t_code      i_code,
    output logic       o_code_take,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [6:0] o_char_code,
    output logic       o_status
);

    t_result          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             res_full;
    logic             do_rd;
    logic [6:0]       raw_ch;
    t_result          result;

    // Decode the head code
    always_comb begin
        raw_ch = lookup_code(i_code.len, i_code.bits);
        result.char_code = raw_ch;
        if (i_lower_case && (raw_ch >= 7'h41) && (raw_ch <= 7'h5A)) begin
            result.char_code = raw_ch | 7'h20;
        end
        result.status = (raw_ch == 7'h00) ? STATUS_ERROR : STATUS_OK;
    end

    assign res_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty     = (r_count == '0);
    assign o_code_take = i_code_valid && !res_full;
    assign do_rd       = i_pop && !o_empty;
    assign o_char_code = r_mem[r_rd_ptr].char_code;
    assign o_status    = r_mem[r_rd_ptr].status;

    // Advance result queue pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (o_code_take) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (o_code_take && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !o_code_take) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store result payload
    always_ff @(posedge i_clk) begin
        if (o_code_take) begin
            r_mem[r_wr_ptr] <= result;
        end
    end

endmodule

@@ rtl/core/morse_symbol_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// morse_symbol_decoder_unit
// International Morse code decoder: symbols in, ASCII characters out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  symbols  | in        | i_push / o_full            | i_symbol, i_end_of_message
//  results  | out       | o_empty / i_pop            | o_char_code, o_status
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (lower case)
//
//  One symbol beat per cycle while o_full is low. A flushed code enters the
//  command queue at the accepting edge; the back end decodes the head code
//  with one table lookup and writes it to the result queue when that queue
//  has room. o_full rises only when both command queue slots are taken,
//  which happens when the result queue is stalled by the consumer. Synchronous
//  active-low reset clears the letter buffer, both queues and the case
//  setting; the config port is always ready.
// ----------------------------------------------------------------------------
module morse_symbol_decoder_unit import msd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_symbol,
    input  logic       i_end_of_message,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [6:0] o_char_code,
    output logic       o_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    logic  r_lower_case;
    logic  accept;
    logic  code_valid;
    t_code code;
    t_code head_code;
    logic  cmd_empty;
    logic  code_take;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !o_full;

    // Hold the case setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_case <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lower_case <= i_cfg_data;
        end
    end

    msd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_symbol         (i_symbol),
        .i_end_of_message (i_end_of_message),
        .o_code_valid     (code_valid),
        .o_code           (code)
    );

    msd_cmd_queue u_cmd_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (code_valid),
        .i_wr_data (code),
        .o_full    (o_full),
        .i_rd      (code_take),
        .o_rd_data (head_code),
        .o_empty   (cmd_empty)
    );

    msd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lower_case (r_lower_case),
        .i_code_valid (!cmd_empty),
        .i_code       (head_code),
        .o_code_take  (code_take),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_char_code  (o_char_code),
        .o_status     (o_status)
    );

endmodule
